>>> hdl/vh_pkg.sv
`timescale 1ns / 1ps
package vh_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 19;
  localparam logic [ACC_W-1:0] ACC_LIMIT = 19'h7FFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_METHOD        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_SAMPLES  = 3'd5;

  localparam logic METHOD_MEAN = 1'b0;
  localparam logic METHOD_MAX  = 1'b1;

  typedef struct packed {
    logic [10:0] row_width;
    logic [10:0] column_height;
    logic [12:0] plane_count;
    logic [2:0]  channel_count;
    logic        method;
    logic        wide_samples;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    row_width:     11'd1024,
    column_height: 11'd1024,
    plane_count:   13'd4096,
    channel_count: 3'd1,
    method:        METHOD_MEAN,
    wide_samples:  1'b0
  };

  typedef struct packed {
    logic       first;
    logic       emit;
    logic       last;
    logic [1:0] channel;
  } flags_t;

endpackage

>>> hdl/volume_halve_2x2x2_mean_max.sv
`timescale 1ns / 1ps
// Halves a volume in each axis by taking the rounded mean or the maximum of every
// 2x2x2 cube. Samples arrive in raster order (x fastest, then row, then plane, then
// channel), one word per cycle while the output is not stalled. Each cube's eighth
// sample passes the front register, the queue and the execute stage, and the cube's
// output word is then registered. The throughput is set by the accumulator memory,
// which takes one read and one write per cycle: each sample is one read-modify-write
// of its cube's entry, with a bypass for back-to-back words that hit the same entry.
// After reset the accumulator memory is cleared, all (MAX_WIDTH/2)*(MAX_HEIGHT/2)
// entries, 262144 at the default sizes, and s_axis_tready stays low until that is done.
// Configuration writes are always taken but must only be made while the block is idle.
module volume_halve_2x2x2_mean_max #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int MAX_DEPTH    = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vh_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // value
  output logic [1:0]                     m_axis_tuser,  // channel
  output logic                           m_axis_tlast
);

  localparam int ACC_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int AW        = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int DW        = AW + vh_pkg::SAMPLE_W + $bits(vh_pkg::flags_t);

  vh_pkg::cfg_t cfg;

  logic                          clearing;
  logic [vh_pkg::QCNT_W-1:0]     q_count;
  logic                          q_push, q_pop, q_valid;
  logic [AW-1:0]                 push_addr, q_addr;
  logic [vh_pkg::SAMPLE_W-1:0]   push_sample, q_sample;
  vh_pkg::flags_t                push_flags, q_flags;
  logic [DW-1:0]                 q_push_data, q_head_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= vh_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        vh_pkg::REG_ROW_WIDTH:     cfg.row_width     <= cfg_data[10:0];
        vh_pkg::REG_COLUMN_HEIGHT: cfg.column_height <= cfg_data[10:0];
        vh_pkg::REG_PLANE_COUNT:   cfg.plane_count   <= cfg_data[12:0];
        vh_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[2:0];
        vh_pkg::REG_METHOD:        cfg.method        <= cfg_data[0];
        vh_pkg::REG_WIDE_SAMPLES:  cfg.wide_samples  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  vh_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_DEPTH    (MAX_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clearing    (clearing),
    .q_count     (q_count),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_sample   (s_axis_tdata),
    .push        (q_push),
    .push_addr   (push_addr),
    .push_sample (push_sample),
    .push_flags  (push_flags)
  );

  assign q_push_data = {push_flags, push_sample, push_addr};

  vh_queue #(
    .DW (DW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head_data),
    .count      (q_count)
  );

  assign {q_flags, q_sample, q_addr} = q_head_data;

  vh_back #(
    .ACC_DEPTH (ACC_DEPTH),
    .AW        (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .method       (cfg.method),
    .wide_samples (cfg.wide_samples),
    .q_valid      (q_valid),
    .q_addr       (q_addr),
    .q_sample     (q_sample),
    .q_flags      (q_flags),
    .pop          (q_pop),
    .clearing     (clearing),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_value    (m_axis_tdata),
    .out_channel  (m_axis_tuser),
    .out_last     (m_axis_tlast)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= vh_pkg::QCNT_W'(vh_pkg::QUEUE_DEPTH))
    else $error("accumulator queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("queue popped while empty");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> (clearing && !s_axis_tready))
    else $error("accumulator clear did not start after reset");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!q_push && !q_pop))
    else $error("sample processed during accumulator clear");

endmodule

>>> hdl/vh_front.sv
`timescale 1ns / 1ps
module vh_front #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int MAX_DEPTH    = 4096,
  parameter int MAX_CHANNELS = 4,
  parameter int AW           = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vh_pkg::cfg_t                  cfg,
  input  logic                          clearing,
  input  logic [vh_pkg::QCNT_W-1:0]     q_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vh_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                          push,
  output logic [AW-1:0]                 push_addr,
  output logic [vh_pkg::SAMPLE_W-1:0]   push_sample,
  output vh_pkg::flags_t                push_flags
);

  localparam int XW  = $clog2(MAX_WIDTH + 1);
  localparam int YW  = $clog2(MAX_HEIGHT + 1);
  localparam int ZW  = $clog2(MAX_DEPTH + 1);
  localparam int CHW = $clog2(MAX_CHANNELS + 1);
  localparam int PW  = (XW - 1) + (YW - 1);

  logic [XW-1:0]  w_c, ew, col_pos, col_inc;
  logic [YW-1:0]  h_c, eh, row_pos, row_inc;
  logic [ZW-1:0]  d_c, ed, plane_pos, plane_inc;
  logic [CHW-1:0] c_c, ch_pos, ch_inc;
  logic           accept, active;
  logic [PW-1:0]  prod_w;
  logic [vh_pkg::SAMPLE_W-1:0] sample_m;

  logic                        f1_valid;
  logic [AW-1:0]               f1_prod;
  logic [AW-1:0]               f1_xh;
  logic [vh_pkg::SAMPLE_W-1:0] f1_sample;
  vh_pkg::flags_t              f1_flags;

  always_comb begin
    if (cfg.row_width < 11'd2) begin
      w_c = XW'(2);
    end else if (32'(cfg.row_width) > MAX_WIDTH) begin
      w_c = XW'(MAX_WIDTH);
    end else begin
      w_c = XW'(cfg.row_width);
    end
    if (cfg.column_height < 11'd2) begin
      h_c = YW'(2);
    end else if (32'(cfg.column_height) > MAX_HEIGHT) begin
      h_c = YW'(MAX_HEIGHT);
    end else begin
      h_c = YW'(cfg.column_height);
    end
    if (cfg.plane_count < 13'd2) begin
      d_c = ZW'(2);
    end else if (32'(cfg.plane_count) > MAX_DEPTH) begin
      d_c = ZW'(MAX_DEPTH);
    end else begin
      d_c = ZW'(cfg.plane_count);
    end
    if (cfg.channel_count < 3'd1) begin
      c_c = CHW'(1);
    end else if (32'(cfg.channel_count) > MAX_CHANNELS) begin
      c_c = CHW'(MAX_CHANNELS);
    end else begin
      c_c = CHW'(cfg.channel_count);
    end
  end

  assign ew = {w_c[XW-1:1], 1'b0};
  assign eh = {h_c[YW-1:1], 1'b0};
  assign ed = {d_c[ZW-1:1], 1'b0};

  assign col_inc   = col_pos + 1'b1;
  assign row_inc   = row_pos + 1'b1;
  assign plane_inc = plane_pos + 1'b1;
  assign ch_inc    = ch_pos + 1'b1;

  assign in_ready = !clearing &&
                    (({1'b0, q_count} + (vh_pkg::QCNT_W + 1)'(f1_valid)) <
                     (vh_pkg::QCNT_W + 1)'(vh_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;
  assign active   = (col_pos < ew) && (row_pos < eh) && (plane_pos < ed);
  assign prod_w   = row_pos[YW-1:1] * w_c[XW-1:1];
  assign sample_m = cfg.wide_samples ? in_sample : {8'h00, in_sample[7:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      row_pos   <= '0;
      plane_pos <= '0;
      ch_pos    <= '0;
    end else if (accept) begin
      if (col_inc >= w_c) begin
        col_pos <= '0;
        if (row_inc >= h_c) begin
          row_pos <= '0;
          if (plane_inc >= d_c) begin
            plane_pos <= '0;
            ch_pos    <= (ch_inc >= c_c) ? '0 : ch_inc;
          end else begin
            plane_pos <= plane_inc;
          end
        end else begin
          row_pos <= row_inc;
        end
      end else begin
        col_pos <= col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept && active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_prod          <= AW'(prod_w);
      f1_xh            <= AW'(col_pos[XW-1:1]);
      f1_sample        <= sample_m;
      f1_flags.first   <= !(col_pos[0] | row_pos[0] | plane_pos[0]);
      f1_flags.emit    <= col_pos[0] & row_pos[0] & plane_pos[0];
      f1_flags.last    <= (col_pos == ew - 1'b1) && (row_pos == eh - 1'b1) &&
                          (plane_pos == ed - 1'b1);
      f1_flags.channel <= 2'(ch_pos);
    end
  end

  assign push        = f1_valid;
  assign push_addr   = f1_prod + f1_xh;
  assign push_sample = f1_sample;
  assign push_flags  = f1_flags;

endmodule

>>> hdl/vh_queue.sv
`timescale 1ns / 1ps
module vh_queue #(
  parameter int DW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [DW-1:0]             push_data,
  input  logic                      pop,
  output logic                      head_valid,
  output logic [DW-1:0]             head_data,
  output logic [vh_pkg::QCNT_W-1:0] count
);

  logic [DW-1:0]             slots [vh_pkg::QUEUE_DEPTH];
  logic [vh_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

endmodule

>>> hdl/vh_back.sv
`timescale 1ns / 1ps
module vh_back #(
  parameter int ACC_DEPTH = 262144,
  parameter int AW        = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        method,
  input  logic                        wide_samples,
  input  logic                        q_valid,
  input  logic [AW-1:0]               q_addr,
  input  logic [vh_pkg::SAMPLE_W-1:0] q_sample,
  input  vh_pkg::flags_t              q_flags,
  output logic                        pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vh_pkg::SAMPLE_W-1:0] out_value,
  output logic [1:0]                  out_channel,
  output logic                        out_last
);

  localparam int AC = vh_pkg::ACC_W;

  logic [AC-1:0] acc_mem [ACC_DEPTH];
  logic [AC-1:0] rd_data;
  logic [AW-1:0] clr_addr;

  logic                        e_valid;
  logic [AW-1:0]               e_addr;
  logic [vh_pkg::SAMPLE_W-1:0] e_sample;
  vh_pkg::flags_t              e_flags;
  logic                        e_fwd;
  logic [AC-1:0]               e_fwd_data;

  logic          e_done, load_e;
  logic [AC-1:0] old_acc, samp_ext, acc_new, v_full, top;
  logic [AC:0]   sum;
  logic [AC:0]   rounded;

  assign e_done = e_valid && (!e_flags.emit || !out_valid || out_ready);
  assign load_e = q_valid && !clearing && (!e_valid || e_done);
  assign pop    = load_e;

  // The previous word writes back on the same edge that this word reads, so
  // its result is carried over instead of the memory's stale data.
  always_comb begin
    old_acc  = e_fwd ? e_fwd_data : rd_data;
    samp_ext = AC'(e_sample);
    sum      = {1'b0, old_acc} + {1'b0, samp_ext};
    if (e_flags.first) begin
      acc_new = samp_ext;
    end else if (method == vh_pkg::METHOD_MAX) begin
      acc_new = (samp_ext > old_acc) ? samp_ext : old_acc;
    end else if (sum > {1'b0, vh_pkg::ACC_LIMIT}) begin
      acc_new = vh_pkg::ACC_LIMIT;
    end else begin
      acc_new = sum[AC-1:0];
    end
    rounded = {1'b0, acc_new} + (AC + 1)'(4);
    v_full  = (method == vh_pkg::METHOD_MAX) ? acc_new : AC'(rounded[AC:3]);
    top     = wide_samples ? AC'(16'hFFFF) : AC'(8'hFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(ACC_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      acc_mem[clr_addr] <= '0;
    end else if (e_done) begin
      acc_mem[e_addr] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (load_e) begin
      rd_data <= acc_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (load_e) begin
      e_valid <= 1'b1;
    end else if (e_done) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_e) begin
      e_addr     <= q_addr;
      e_sample   <= q_sample;
      e_flags    <= q_flags;
      e_fwd      <= e_done && (e_addr == q_addr);
      e_fwd_data <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_done && e_flags.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_done && e_flags.emit) begin
      out_value   <= (v_full > top) ? top[vh_pkg::SAMPLE_W-1:0] :
                                      v_full[vh_pkg::SAMPLE_W-1:0];
      out_channel <= e_flags.channel;
      out_last    <= e_flags.last;
    end
  end

endmodule

>>> tb/volume_halve_2x2x2_mean_max_tb.sv
`timescale 1ns / 1ps
module volume_halve_2x2x2_mean_max_tb;
  import vh_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 1_200_000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int SIDE_MAX_W     = 1024;
  localparam int SIDE_MAX_H     = 1024;
  localparam int DEPTH_MAX      = 4096;
  localparam int CHANNELS_MAX   = 4;
  localparam int CUBE_SLOTS     = (SIDE_MAX_W / 2) * (SIDE_MAX_H / 2);
  localparam int RANDOM_VOXELS  = 550;

  typedef struct {
    logic [15:0] sample;
    logic        hold;
  } voxel_t;

  typedef struct {
    logic [15:0] value;
    logic [1:0]  channel;
    logic        last;
  } cube_result_t;

  typedef enum int {ALWAYS_READY, COIN_FLIP, PERIODIC, SPARSE} stall_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // value
  logic [1:0] m_axis_tuser;  // channel
  logic m_axis_tlast;

  voxel_t voxels_pending[$];
  cube_result_t cubes_due[$];
  int unsigned voxels_queued = 0;
  int unsigned voxels_taken = 0;
  int unsigned mismatches = 0;

  cfg_t shadow_cfg = CFG_RESET;
  bit [ACC_W-1:0] cube_sum[CUBE_SLOTS];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned plane_pos = 0;
  int unsigned channel_pos = 0;

  volume_halve_2x2x2_mean_max i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned fit(input int unsigned v, input int unsigned lo,
                                      input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Folds one accepted voxel into the cube sums and queues the cube result it completes.
  task automatic halve_voxel(input logic [15:0] word);
    int unsigned w, h, d, c, ew, eh, ed, x, y, z, s, slot, acc, top, v;
    cube_result_t res;
    w = fit(shadow_cfg.row_width, 2, SIDE_MAX_W);
    h = fit(shadow_cfg.column_height, 2, SIDE_MAX_H);
    d = fit(shadow_cfg.plane_count, 2, DEPTH_MAX);
    c = fit(shadow_cfg.channel_count, 1, CHANNELS_MAX);
    ew = w & 32'hFFFF_FFFE;
    eh = h & 32'hFFFF_FFFE;
    ed = d & 32'hFFFF_FFFE;
    x = col_pos;
    y = row_pos;
    z = plane_pos;
    s = shadow_cfg.wide_samples ? word : word[7:0];
    if (x < ew && y < eh && z < ed) begin
      slot = (y >> 1) * (ew >> 1) + (x >> 1);
      acc = cube_sum[slot];
      if (((x | y | z) & 1) == 0) begin
        acc = s;
      end else if (shadow_cfg.method == METHOD_MAX) begin
        if (s > acc) acc = s;
      end else begin
        acc = acc + s;
        if (acc > ACC_LIMIT) acc = ACC_LIMIT;
      end
      cube_sum[slot] = acc[ACC_W-1:0];
      if ((x & y & z & 1) != 0) begin
        top = shadow_cfg.wide_samples ? 32'hFFFF : 32'hFF;
        v = (shadow_cfg.method == METHOD_MAX) ? acc : (acc + 4) >> 3;
        if (v > top) v = top;
        res.value = v[15:0];
        res.channel = channel_pos[1:0];
        res.last = (x == ew - 1 && y == eh - 1 && z == ed - 1);
        cubes_due.push_back(res);
      end
    end
    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h) begin
        row_pos = 0;
        plane_pos = z + 1;
        if (plane_pos >= d) begin
          plane_pos = 0;
          channel_pos = channel_pos + 1;
          if (channel_pos >= c) channel_pos = 0;
        end
      end
    end
  endtask

  // Called at a clock edge; leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROW_WIDTH: shadow_cfg.row_width = value[10:0];
      REG_COLUMN_HEIGHT: shadow_cfg.column_height = value[10:0];
      REG_PLANE_COUNT: shadow_cfg.plane_count = value[12:0];
      REG_CHANNEL_COUNT: shadow_cfg.channel_count = value[2:0];
      REG_METHOD: shadow_cfg.method = value[0];
      REG_WIDE_SAMPLES: shadow_cfg.wide_samples = value[0];
      default: ;
    endcase
  endtask

  task automatic queue_voxel(input logic [15:0] sample, input logic hold);
    voxels_pending.push_back('{sample: sample, hold: hold});
    voxels_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (voxels_taken != voxels_queued || cubes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {8'($urandom), 8'hFF};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    logic [10:0] side;
    case ($urandom_range(0, 19))
      0: side = 11'($urandom_range(0, 1));
      1: side = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
      2, 3: side = 11'($urandom_range(7, 12));
      default: side = 11'($urandom_range(2, 6));
    endcase
    return {2'($urandom), side};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_planes();
    case ($urandom_range(0, 19))
      0: return 13'($urandom_range(0, 1));
      1: return 13'($urandom_range(4096, 8191));
      2, 3: return 13'($urandom_range(7, 12));
      default: return 13'($urandom_range(2, 6));
    endcase
  endfunction

  always @(posedge clk) begin : drive_voxels
    logic free;
    logic next_valid;
    voxel_t next;
    int unsigned gap_left;
    int unsigned burst_left;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      free = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        halve_voxel(s_axis_tdata);
        voxels_taken++;
        free = 1'b1;
      end
      if (free) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (voxels_pending.size() != 0 &&
                     !(voxels_pending[0].hold && cubes_due.size() != 0)) begin
          next = voxels_pending.pop_front();
          s_axis_tdata <= next.sample;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  always @(posedge clk) begin : check_cubes
    cube_result_t want;
    stall_mode_t stall_mode;
    int unsigned mode_left;
    int unsigned beat;
    logic ready;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_mode = ALWAYS_READY;
      mode_left = 0;
      beat = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cubes_due.size() == 0) begin
          $error("unexpected output word: value %0d, channel %0d, last %0d",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = cubes_due.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("value mismatch: expected %0d, got %0d", want.value, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want.channel) begin
            $error("channel mismatch: expected %0d, got %0d", want.channel, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      beat++;
      case (stall_mode)
        ALWAYS_READY: ready = 1'b1;
        COIN_FLIP: ready = 1'($urandom);
        PERIODIC: ready = (beat % 5) > 1;
        default: ready = ($urandom_range(0, 3) == 0);
      endcase
      m_axis_tready <= ready;
    end
  end

  initial begin
    int unsigned total;
    int unsigned count;
    int unsigned hold_at;
    int unsigned phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full-scale wide samples over two channels; the ninth word waits for the first cube.
    write_reg(REG_ROW_WIDTH, 13'd2);
    write_reg(REG_COLUMN_HEIGHT, 13'd2);
    write_reg(REG_PLANE_COUNT, 13'd2);
    write_reg(REG_CHANNEL_COUNT, 13'd2);
    write_reg(REG_METHOD, 13'(METHOD_MEAN));
    write_reg(REG_WIDE_SAMPLES, 13'd1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 16; i++) queue_voxel((i < 8) ? 16'hFFFF : 16'h0000, i == 8);
    wait_idle();

    // Narrow maximum on a 3x2x2 volume, so the odd column is dropped and upper bytes vary.
    write_reg(REG_ROW_WIDTH, 13'd3);
    write_reg(REG_METHOD, 13'(METHOD_MAX));
    write_reg(REG_WIDE_SAMPLES, 13'd0);
    write_reg(REG_CHANNEL_COUNT, 13'd1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 12; i++) queue_voxel({8'($urandom), 8'(i * 23)}, 1'b0);
    wait_idle();

    total = 0;
    phase = 0;
    while (total < RANDOM_VOXELS) begin
      if (phase == 0) begin
        write_reg(REG_ROW_WIDTH, 13'd0);
        write_reg(REG_COLUMN_HEIGHT, 13'd1);
        write_reg(REG_PLANE_COUNT, 13'h1FFF);
        write_reg(REG_CHANNEL_COUNT, 13'h1FFF);
        write_reg(REG_METHOD, 13'(METHOD_MAX));
        write_reg(REG_WIDE_SAMPLES, 13'd1);
      end else if (phase == 1) begin
        write_reg(REG_ROW_WIDTH, 13'h1FFF);
        write_reg(REG_COLUMN_HEIGHT, 13'h07FF);
        write_reg(REG_PLANE_COUNT, 13'd0);
        write_reg(REG_CHANNEL_COUNT, 13'd0);
        write_reg(REG_METHOD, 13'(METHOD_MEAN));
        write_reg(REG_WIDE_SAMPLES, 13'd0);
      end else begin
        write_reg(REG_ROW_WIDTH, pick_side());
        write_reg(REG_COLUMN_HEIGHT, pick_side());
        write_reg(REG_PLANE_COUNT, pick_planes());
        write_reg(REG_CHANNEL_COUNT, 13'($urandom));
        write_reg(REG_METHOD, 13'($urandom));
        write_reg(REG_WIDE_SAMPLES, 13'($urandom));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_WIDE_SAMPLES + 3'(1 + $urandom_range(0, 1)), 13'($urandom));
      cfg_valid <= 1'b0;
      count = $urandom_range(16, 72);
      hold_at = $urandom_range(0, 2 * count);
      for (int i = 0; i < count; i++) queue_voxel(pick_sample(), i == hold_at);
      total += count;
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

endmodule
